// ===== design/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// sact_pkg: shared types and constants of the cache tag directory
// Configuration register indexes, the configuration bundle and the result.
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

  localparam logic [1:0] CFG_DIRECT_MODE   = 2'd0;
  localparam logic [1:0] CFG_RANDOM_POLICY = 2'd1;
  localparam logic [1:0] CFG_RANDOM_SEED   = 2'd2;

  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [15:0] USE_MAX    = 16'hFFFF;

  typedef struct packed {
    logic        direct_mode;
    logic        random_policy;
    logic        seed_we;
    logic [15:0] seed;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [3:0]  way;
    logic [13:0] line_index;
    logic [47:0] hits_total;
    logic [47:0] misses_total;
    logic [47:0] replacements_total;
  } res_t;

endpackage

`default_nettype wire

// ===== design/sact_if.sv =====
// ----------------------------------------------------------------------------
// sact_if: item channels of the cache tag directory
// Access channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface sact_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [47:0] address;
  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

interface sact_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted;
  logic [3:0]  way;
  logic [13:0] line_index;
  logic [47:0] hits_total;
  logic [47:0] misses_total;
  logic [47:0] replacements_total;
  modport source (output valid, output hit, output evicted, output way, output line_index,
                  output hits_total, output misses_total, output replacements_total,
                  input ready);
  modport sink (input valid, input hit, input evicted, input way, input line_index,
                input hits_total, input misses_total, input replacements_total,
                output ready);
endinterface

`default_nettype wire

// ===== design/set_assoc_cache_tag_model.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_model: set-associative cache tag directory
// Tag-only directory with direct or associative lookup and least-used or
// pseudo-random replacement, plus running hit, miss and replacement totals.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Item contents
//   in_ch    in         valid/ready    kind (access or flush), address
//   out_ch   out        valid/ready    hit, evicted, way, line_index, totals
//   cfg_*    in         cfg_we only    register index and write data
//
// In the back end an access item first has the set's row read into registers,
// then the compare, victim choice and row write-back, which wait while the
// output register holds a stalled result. The front end decodes the next item
// meanwhile and a two-entry queue buffers it. A flush item walks every set, one
// row per cycle. After reset the same walk clears valid bits and use counts;
// no item is accepted while it runs. A stalled result stays in the output
// register and holds the back end, while the front end keeps filling the
// queue.
`default_nettype none

module set_assoc_cache_tag_model import sact_pkg::*; #(
  parameter int WAYS       = 16,
  parameter int SETS       = 1024,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sact_in_if.sink          in_ch,
  sact_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // Address split widths, log2 rounded down as the directory defines it.
  localparam int OB    = $clog2(LINE_BYTES + 1) - 1;
  localparam int SB    = $clog2(SETS + 1) - 1;
  localparam int AW    = (ADDR_BITS < 48) ? ADDR_BITS : 48;
  localparam int TAG_W = AW - OB - SB;
  localparam int WIX   = $clog2(WAYS);
  localparam int RW    = $clog2(SETS);
  // Queue word: kind, mode, row, direct way, tag, line index.
  localparam int QW    = 2 + RW + WIX + TAG_W + 14;

  logic          direct_mode_r;
  logic          random_policy_r;
  cfg_t          cfg;

  logic          q_push, q_full, q_pop, q_empty, init_busy;
  logic [QW-1:0] q_din, q_dout;
  logic          res_valid;
  res_t          res;

  // Configuration registers. A seed write loads the eviction LFSR directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direct_mode_r   <= 1'b0;
      random_policy_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DIRECT_MODE) direct_mode_r <= cfg_wdata[0];
      if (cfg_index == CFG_RANDOM_POLICY) random_policy_r <= cfg_wdata[0];
    end
  end

  always_comb begin
    cfg.direct_mode   = direct_mode_r;
    cfg.random_policy = random_policy_r;
    cfg.seed_we       = cfg_we && (cfg_index == CFG_RANDOM_SEED);
    cfg.seed          = cfg_wdata;
  end

  sact_front #(
    .WAYS(WAYS), .SETS(SETS), .LINE_BYTES(LINE_BYTES), .ADDR_BITS(ADDR_BITS),
    .TAG_W(TAG_W), .QW(QW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .direct_mode(direct_mode_r),
    .hold(init_busy), .q_full(q_full), .q_push(q_push), .q_data(q_din)
  );

  sact_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  sact_back #(.WAYS(WAYS), .SETS(SETS), .TAG_W(TAG_W), .QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(!q_empty), .q_data(q_dout),
    .q_pop(q_pop), .init_busy(init_busy), .res_valid(res_valid), .res(res),
    .res_ready(out_ch.ready)
  );

  assign out_ch.valid              = res_valid;
  assign out_ch.hit                = res.hit;
  assign out_ch.evicted            = res.evicted;
  assign out_ch.way                = res.way;
  assign out_ch.line_index         = res.line_index;
  assign out_ch.hits_total         = res.hits_total;
  assign out_ch.misses_total       = res.misses_total;
  assign out_ch.replacements_total = res.replacements_total;

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command queue overflow");

  // The back end only pops a command that is there.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("command queue underflow");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.evicted)) else $error("hit with eviction");

  // While the reset clearing walk runs, no item enters.
  a_init_hold: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !in_ch.ready) else $error("item accepted during clearing walk");

endmodule

`default_nettype wire

// ===== design/sact_front.sv =====
// ----------------------------------------------------------------------------
// sact_front: address decode front end
// Splits an access address into row, way, tag and line index and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_front import sact_pkg::*; #(
  parameter int WAYS       = 16,
  parameter int SETS       = 1024,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 48,
  parameter int TAG_W      = 32,
  parameter int QW         = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  sact_in_if.sink      in_ch,
  input  wire logic    direct_mode,
  input  wire logic    hold,
  input  wire logic    q_full,
  output logic         q_push,
  output logic [QW-1:0] q_data
);

  localparam int OB  = $clog2(LINE_BYTES + 1) - 1;
  localparam int SB  = $clog2(SETS + 1) - 1;
  localparam int WB  = $clog2(WAYS + 1) - 1;
  localparam int WIX = $clog2(WAYS);
  localparam int RW  = $clog2(SETS);
  localparam int DW  = SB + WB;
  localparam int AW  = (ADDR_BITS < 48) ? ADDR_BITS : 48;
  localparam logic [47:0] AMASK = (AW >= 48) ? 48'hFFFF_FFFF_FFFF
                                             : ((48'd1 << AW) - 48'd1);
  // Reciprocal of WAYS, scaled by 2^DW, for the direct-mode row split.
  localparam logic [DW-1:0] MR = DW'((2 ** DW) / WAYS);

  logic              acc;
  logic [47:0]       addr_m;
  logic [DW-1:0]     d_c;
  logic [SB-1:0]     set_c;
  logic [TAG_W-1:0]  tag_c;
  logic [DW+13:0]    dz;
  logic [SB+13:0]    sz;
  logic [13:0]       lidx_c;

  logic              s1_v_r;
  logic              s1_kind_r;
  logic              s1_dm_r;
  logic [DW-1:0]     s1_d_r;
  logic [2*DW-1:0]   s1_prod_r;
  logic [SB-1:0]     s1_set_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic [13:0]       s1_lidx_r;

  logic [DW-1:0]     q0;
  logic [DW+4:0]     qw;
  logic [DW+4:0]     rem_w;
  logic [DW-1:0]     quo;
  logic [DW+4:0]     rem;
  logic [RW-1:0]     row;

  assign in_ch.ready = !hold && (!s1_v_r || !q_full);
  assign acc         = in_ch.valid && in_ch.ready;
  assign q_push      = s1_v_r && !q_full;

  always_comb begin
    addr_m = in_ch.address & AMASK;
    d_c    = DW'(addr_m >> OB);
    set_c  = SB'(addr_m >> OB);
    dz     = (DW + 14)'(d_c);
    sz     = (SB + 14)'(set_c);
    if (direct_mode) begin
      tag_c  = TAG_W'(addr_m >> (OB + SB + WB));
      lidx_c = dz[13:0];
    end else begin
      tag_c  = TAG_W'(addr_m >> (OB + SB));
      lidx_c = sz[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (q_push) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r <= in_ch.kind;
      s1_dm_r   <= direct_mode;
      s1_d_r    <= d_c;
      s1_prod_r <= (2 * DW)'(d_c) * (2 * DW)'(MR);
      s1_set_r  <= set_c;
      s1_tag_r  <= tag_c;
      s1_lidx_r <= lidx_c;
    end
  end

  // The scaled product underestimates the quotient by at most one.
  always_comb begin
    q0    = s1_prod_r[2*DW-1:DW];
    qw    = (DW + 5)'(q0) * (DW + 5)'(WAYS);
    rem_w = (DW + 5)'(s1_d_r) - qw;
    if (rem_w >= (DW + 5)'(WAYS)) begin
      quo = q0 + DW'(1);
      rem = rem_w - (DW + 5)'(WAYS);
    end else begin
      quo = q0;
      rem = rem_w;
    end
    row    = s1_dm_r ? quo[RW-1:0] : RW'(s1_set_r);
    q_data = {s1_kind_r, s1_dm_r, row, rem[WIX-1:0], s1_tag_r, s1_lidx_r};
  end

endmodule

`default_nettype wire

// ===== design/sact_fifo.sv =====
// ----------------------------------------------------------------------------
// sact_fifo: two-entry command queue
// Decouples the decode front end from the directory back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_fifo import sact_pkg::*; #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  logic [W-1:0] buf_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= din;
  end

endmodule

`default_nettype wire

// ===== design/sact_back.sv =====
// ----------------------------------------------------------------------------
// sact_back: directory back end
// Holds valid, tag and use-count rows, looks commands up and writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_back import sact_pkg::*; #(
  parameter int WAYS  = 16,
  parameter int SETS  = 1024,
  parameter int TAG_W = 32,
  parameter int QW    = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          q_valid,
  input  wire logic [QW-1:0] q_data,
  output logic               q_pop,
  output logic               init_busy,
  output logic               res_valid,
  output res_t               res,
  input  wire logic          res_ready
);

  localparam int WB  = $clog2(WAYS + 1) - 1;
  localparam int WIX = $clog2(WAYS);
  localparam int RW  = $clog2(SETS);
  localparam int NP  = 2 ** WIX;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_FDONE = 4'b1000
  } st_t;

  st_t st_r, st_nxt;

  logic               q_kind;
  logic               q_dm;
  logic [RW-1:0]      q_row;
  logic [WIX-1:0]     q_dway;
  logic [TAG_W-1:0]   q_tag;
  logic [13:0]        q_lidx;

  logic               c_dm_r;
  logic [RW-1:0]      c_row_r;
  logic [WIX-1:0]     c_dway_r;
  logic [TAG_W-1:0]   c_tag_r;
  logic [13:0]        c_lidx_r;

  logic [RW-1:0]      clr_r;
  logic               clr_init_r;

  logic [WAYS-1:0]         valid_mem [SETS];
  logic [WAYS*TAG_W-1:0]   tag_mem   [SETS];
  logic [WAYS*16-1:0]      use_mem   [SETS];
  logic [WAYS-1:0]         rd_valid_r;
  logic [WAYS*TAG_W-1:0]   rd_tag_r;
  logic [WAYS*16-1:0]      rd_use_r;

  logic [47:0] hits_r, misses_r, repl_r;
  logic [47:0] hits_nxt, misses_nxt, repl_nxt;
  logic [15:0] lfsr_r, lfsr_step;
  logic        lfsr_adv;

  logic        slot_free;
  logic        done;
  logic        fdone;
  logic        rd_en;
  logic        we_v, we_t, we_u;
  logic [RW-1:0]           wa;
  logic [WAYS-1:0]         nv;
  logic [WAYS*TAG_W-1:0]   nt;
  logic [WAYS*16-1:0]      nu;

  logic [WAYS-1:0]  match;
  logic             any_match, any_empty;
  logic [WIX-1:0]   f_way, e_way, victim, pick, lk_way;
  logic             lk_hit, lk_evict;

  logic [NP*16-1:0] usepad;
  logic [15:0]      tv [WIX+1][NP];
  logic [WIX-1:0]   ti [WIX+1][NP];

  logic        res_valid_r;
  res_t        res_r;

  assign {q_kind, q_dm, q_row, q_dway, q_tag, q_lidx} = q_data;

  assign slot_free = !res_valid_r || res_ready;
  assign q_pop     = (st_r == ST_IDLE) && q_valid;
  assign rd_en     = q_pop && !q_kind;
  assign done      = (st_r == ST_LOOK) && slot_free;
  assign fdone     = (st_r == ST_FDONE) && slot_free;
  assign init_busy = (st_r == ST_CLEAR) && clr_init_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // LFSR step: taps 16, 14, 13, 11, shifting right.
  assign lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
  assign pick      = WIX'(lfsr_step >> (16 - WB));

  // Least-used way: registered-free tree, left side wins on ties.
  always_comb begin
    usepad = '1;
    usepad[WAYS*16-1:0] = rd_use_r;
    for (int l = 0; l <= WIX; l++) begin
      for (int i = 0; i < NP; i++) begin
        tv[l][i] = '0;
        ti[l][i] = '0;
      end
    end
    for (int i = 0; i < NP; i++) begin
      tv[0][i] = usepad[i*16 +: 16];
      ti[0][i] = WIX'(i);
    end
    for (int l = 0; l < WIX; l++) begin
      for (int i = 0; i < (NP >> (l + 1)); i++) begin
        if (tv[l][2*i+1] < tv[l][2*i]) begin
          tv[l+1][i] = tv[l][2*i+1];
          ti[l+1][i] = ti[l][2*i+1];
        end else begin
          tv[l+1][i] = tv[l][2*i];
          ti[l+1][i] = ti[l][2*i];
        end
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = rd_valid_r[w] && (rd_tag_r[w*TAG_W +: TAG_W] == c_tag_r);
    end
    any_match = |match;
    any_empty = !(&rd_valid_r);
    f_way = '0;
    e_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) f_way = WIX'(w);
      if (!rd_valid_r[w]) e_way = WIX'(w);
    end
    victim = cfg.random_policy ? pick : ti[WIX][0];
  end

  // Row update for the lookup in flight.
  always_comb begin
    nv       = rd_valid_r;
    nt       = rd_tag_r;
    nu       = rd_use_r;
    lk_hit   = 1'b0;
    lk_evict = 1'b0;
    lk_way   = '0;
    lfsr_adv = 1'b0;
    if (c_dm_r) begin
      lk_hit = match[c_dway_r];
      if (!lk_hit) begin
        nv[c_dway_r] = 1'b1;
        nt[c_dway_r*TAG_W +: TAG_W] = c_tag_r;
      end
    end else if (any_match) begin
      lk_hit = 1'b1;
      lk_way = f_way;
      if (!cfg.random_policy && (rd_use_r[f_way*16 +: 16] != USE_MAX)) begin
        nu[f_way*16 +: 16] = rd_use_r[f_way*16 +: 16] + 16'd1;
      end
    end else if (any_empty) begin
      lk_way = e_way;
      nv[e_way] = 1'b1;
      nt[e_way*TAG_W +: TAG_W] = c_tag_r;
    end else begin
      lk_evict = 1'b1;
      lk_way   = victim;
      lfsr_adv = cfg.random_policy;
      nt[victim*TAG_W +: TAG_W] = c_tag_r;
      if (!cfg.random_policy) nu[victim*16 +: 16] = 16'd0;
    end
  end

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    repl_nxt   = repl_r;
    if (done) begin
      if (lk_hit) begin
        hits_nxt = hits_r + 48'd1;
      end else begin
        misses_nxt = misses_r + 48'd1;
      end
      if (lk_evict) repl_nxt = repl_r + 48'd1;
    end
  end

  always_comb begin
    we_v = 1'b0;
    we_t = 1'b0;
    we_u = 1'b0;
    wa   = c_row_r;
    if (st_r == ST_CLEAR) begin
      we_v = 1'b1;
      we_u = clr_init_r;
      wa   = clr_r;
    end else if (done) begin
      we_v = 1'b1;
      we_t = 1'b1;
      we_u = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_r == RW'(SETS - 1)) st_nxt = clr_init_r ? ST_IDLE : ST_FDONE;
      end
      ST_IDLE: begin
        if (q_valid) st_nxt = q_kind ? ST_CLEAR : ST_LOOK;
      end
      ST_LOOK: begin
        if (slot_free) st_nxt = ST_IDLE;
      end
      ST_FDONE: begin
        if (slot_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      clr_init_r  <= 1'b1;
      hits_r      <= '0;
      misses_r    <= '0;
      repl_r      <= '0;
      lfsr_r      <= SEED_RESET;
      res_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      repl_r   <= repl_nxt;
      if (st_r == ST_CLEAR) begin
        clr_r <= (clr_r == RW'(SETS - 1)) ? '0 : clr_r + RW'(1);
      end
      if (q_pop && q_kind) clr_init_r <= 1'b0;
      if (cfg.seed_we) begin
        lfsr_r <= cfg.seed;
      end else if (done && lfsr_adv) begin
        lfsr_r <= lfsr_step;
      end
      if (done || fdone) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      c_dm_r   <= q_dm;
      c_row_r  <= q_row;
      c_dway_r <= q_dway;
      c_tag_r  <= q_tag;
      c_lidx_r <= q_lidx;
    end
    if (done) begin
      res_r.hit                <= lk_hit;
      res_r.evicted            <= lk_evict;
      res_r.way                <= 4'(lk_way);
      res_r.line_index         <= c_lidx_r;
      res_r.hits_total         <= hits_nxt;
      res_r.misses_total       <= misses_nxt;
      res_r.replacements_total <= repl_nxt;
    end else if (fdone) begin
      res_r.hit                <= 1'b0;
      res_r.evicted            <= 1'b0;
      res_r.way                <= 4'd0;
      res_r.line_index         <= 14'd0;
      res_r.hits_total         <= hits_r;
      res_r.misses_total       <= misses_r;
      res_r.replacements_total <= repl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_v) valid_mem[wa] <= (st_r == ST_CLEAR) ? '0 : nv;
    if (we_t) tag_mem[wa] <= nt;
    if (we_u) use_mem[wa] <= (st_r == ST_CLEAR) ? '0 : nu;
    if (rd_en) begin
      rd_valid_r <= valid_mem[q_row];
      rd_tag_r   <= tag_mem[q_row];
      rd_use_r   <= use_mem[q_row];
    end
  end

endmodule

`default_nettype wire
